FILE: src/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg
// Shared types, codes and the saturation helper of the vector ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package v3a_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int DW        = 32;             // field width
  localparam int PW        = 2 * DW;         // full product width
  localparam int SW        = PW + 2;         // exact sum of three products
  localparam int QW        = FRAC_BITS + 1;  // normalize quotient width

  typedef enum logic [3:0] {
    ACT_DOT   = 4'd0,
    ACT_CROSS = 4'd1,
    ACT_ADD   = 4'd2,
    ACT_SUB   = 4'd3,
    ACT_NEG   = 4'd4,
    ACT_SCALE = 4'd5,
    ACT_SQLEN = 4'd6,
    ACT_LEN   = 4'd7,
    ACT_NORM  = 4'd8
  } act_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [3:0]             action;
    logic signed [DW-1:0]   a_x;
    logic signed [DW-1:0]   a_y;
    logic signed [DW-1:0]   a_z;
    logic signed [DW-1:0]   b_x;
    logic signed [DW-1:0]   b_y;
    logic signed [DW-1:0]   b_z;
    logic signed [DW-1:0]   scale_factor;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0]   res_x;
    logic signed [DW-1:0]   res_y;
    logic signed [DW-1:0]   res_z;
    logic signed [DW-1:0]   res_scalar;
    logic [1:0]             status;
  } out_t;

  // Travels beside the root and divide pipelines.
  typedef struct packed {
    logic [3:0]             action;
    logic [2:0]             neg;
    logic [2:0][DW-1:0]     mag;
    logic signed [DW-1:0]   vx;
    logic signed [DW-1:0]   vy;
    logic signed [DW-1:0]   vz;
    logic signed [DW-1:0]   sc;
    logic [1:0]             status;
  } side_t;

  localparam logic signed [SW-1:0] SAT_HI =
    {{(SW - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  // Returns {saturated, low field bits of the clamped value}.
  function automatic logic [DW:0] sat_word(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    logic                 f;
    c = v;
    f = 1'b0;
    if (v > SAT_HI) begin
      c = SAT_HI;
      f = 1'b1;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
      f = 1'b1;
    end
    return {f, c[DW-1:0]};
  endfunction

endpackage

FILE: src/v3a_front.sv
// ----------------------------------------------------------------------------
// v3a_front
// Three stages: products, exact sums, floor shift and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module v3a_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  v3a_pkg::in_t     item,
  output logic             out_valid,
  output logic [v3a_pkg::PW-1:0] sumsq,
  output v3a_pkg::side_t   side
);
  import v3a_pkg::*;

  // Stage 1 registers.
  logic                 v1;
  logic [3:0]           act1;
  logic signed [PW-1:0] m [6];
  logic signed [DW:0]   simp [3];
  logic [2:0][DW-1:0]   mag1;
  logic [2:0]           neg1;

  // Stage 2 registers.
  logic                 v2;
  logic [3:0]           act2;
  logic signed [SW-1:0] e [3];
  logic signed [SW-1:0] t;
  logic [2:0][DW-1:0]   mag2;
  logic [2:0]           neg2;

  logic signed [DW-1:0] o0, o1, o2;
  logic signed [DW:0]   simp_next [3];
  logic signed [DW-1:0] av [3];
  logic signed [DW-1:0] bv [3];
  logic [2:0][DW-1:0]   mag_next;

  assign av[0] = item.a_x;
  assign av[1] = item.a_y;
  assign av[2] = item.a_z;
  assign bv[0] = item.b_x;
  assign bv[1] = item.b_y;
  assign bv[2] = item.b_z;

  always_comb begin
    case (item.action)
      ACT_DOT: begin
        o0 = item.b_x; o1 = item.b_y; o2 = item.b_z;
      end
      ACT_CROSS: begin
        o0 = item.b_y; o1 = item.b_z; o2 = item.b_x;
      end
      ACT_SCALE: begin
        o0 = item.scale_factor; o1 = item.scale_factor; o2 = item.scale_factor;
      end
      default: begin
        o0 = item.a_x; o1 = item.a_y; o2 = item.a_z;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      case (item.action)
        ACT_ADD: simp_next[i] = {av[i][DW-1], av[i]} + {bv[i][DW-1], bv[i]};
        ACT_SUB: simp_next[i] = {av[i][DW-1], av[i]} - {bv[i][DW-1], bv[i]};
        default: simp_next[i] = -{av[i][DW-1], av[i]};
      endcase
      mag_next[i] = av[i][DW-1] ? (~av[i] + 1'b1) : av[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      act1 <= item.action;
      m[0] <= PW'(item.a_x) * PW'(o0);
      m[1] <= PW'(item.a_y) * PW'(o1);
      m[2] <= PW'(item.a_z) * PW'(o2);
      m[3] <= PW'(item.b_y) * PW'(item.a_z);
      m[4] <= PW'(item.b_z) * PW'(item.a_x);
      m[5] <= PW'(item.b_x) * PW'(item.a_y);
      for (int i = 0; i < 3; i++) begin
        simp[i] <= simp_next[i];
      end
      mag1 <= mag_next;
      neg1 <= {item.a_z[DW-1], item.a_y[DW-1], item.a_x[DW-1]};
    end
  end

  logic signed [SW-1:0] mx [6];
  logic signed [SW-1:0] e_next [3];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      mx[i] = {{2{m[i][PW-1]}}, m[i]};
    end
    for (int i = 0; i < 3; i++) begin
      case (act1)
        ACT_ADD, ACT_SUB, ACT_NEG: begin
          // Placed above the binary point so that the common shift restores it.
          e_next[i] = {{(SW - DW - 1 - FRAC_BITS){simp[i][DW]}}, simp[i],
                       {FRAC_BITS{1'b0}}};
        end
        default: e_next[i] = mx[i];
      endcase
    end
    if (act1 == ACT_CROSS) begin
      e_next[0] = mx[1] - mx[3];
      e_next[1] = mx[2] - mx[4];
      e_next[2] = mx[0] - mx[5];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      act2 <= act1;
      for (int i = 0; i < 3; i++) begin
        e[i] <= e_next[i];
      end
      t    <= mx[0] + mx[1] + mx[2];
      mag2 <= mag1;
      neg2 <= neg1;
    end
  end

  logic [DW:0] sv [3];
  logic [DW:0] ss;
  side_t       side_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv[i] = sat_word(e[i] >>> FRAC_BITS);
    end
    ss = sat_word(t >>> FRAC_BITS);
    side_next        = '0;
    side_next.action = act2;
    side_next.neg    = neg2;
    side_next.mag    = mag2;
    side_next.status = ST_OK;
    case (act2)
      ACT_CROSS, ACT_ADD, ACT_SUB, ACT_NEG, ACT_SCALE: begin
        side_next.vx = sv[0][DW-1:0];
        side_next.vy = sv[1][DW-1:0];
        side_next.vz = sv[2][DW-1:0];
        if (sv[0][DW] || sv[1][DW] || sv[2][DW]) begin
          side_next.status = ST_SAT;
        end
      end
      ACT_DOT, ACT_SQLEN: begin
        side_next.sc = ss[DW-1:0];
        if (ss[DW]) begin
          side_next.status = ST_SAT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      side  <= side_next;
      sumsq <= t[PW-1:0];
    end
  end

endmodule

FILE: src/v3a_sqrt.sv
// ----------------------------------------------------------------------------
// v3a_sqrt
// Integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module v3a_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [v3a_pkg::PW-1:0] x,
  input  v3a_pkg::side_t   side_in,
  output logic             out_valid,
  output logic [v3a_pkg::DW-1:0] root_out,
  output v3a_pkg::side_t   side_out
);
  import v3a_pkg::*;

  localparam int NS = DW;
  localparam int RW = DW + 2;

  logic          vld  [NS+1];
  logic [RW-1:0] rem  [NS+1];
  logic [DW-1:0] root [NS+1];
  logic [PW-1:0] xs   [NS+1];
  side_t         sd   [NS+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign xs[0]   = x;
  assign sd[0]   = side_in;

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [RW-1:0] rsh;
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_next;
    logic [DW-1:0] root_next;

    always_comb begin
      rsh   = {rem[k][RW-3:0], xs[k][PW-1 -: 2]};
      trial = {root[k], 2'b01};
      if (rsh >= trial) begin
        rem_next  = rsh - trial;
        root_next = {root[k][DW-2:0], 1'b1};
      end else begin
        rem_next  = rsh;
        root_next = {root[k][DW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1]  <= rem_next;
        root[k+1] <= root_next;
        xs[k+1]   <= {xs[k][PW-3:0], 2'b00};
        sd[k+1]   <= sd[k];
      end
    end
  end

  assign out_valid = vld[NS];
  assign root_out  = root[NS];
  assign side_out  = sd[NS];

endmodule

FILE: src/v3a_div.sv
// ----------------------------------------------------------------------------
// v3a_div
// Three-lane restoring divider for normalize, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module v3a_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [v3a_pkg::DW-1:0] d_in,
  input  v3a_pkg::side_t   side_in,
  output logic             out_valid,
  output logic [v3a_pkg::DW-1:0] d_out,
  output logic [2:0][v3a_pkg::QW-1:0] q_out,
  output v3a_pkg::side_t   side_out
);
  import v3a_pkg::*;

  localparam int RW = DW + QW;

  logic                 vld [QW+1];
  logic [DW-1:0]        dd  [QW+1];
  logic [2:0][RW-1:0]   rem [QW+1];
  logic [2:0][QW-1:0]   qq  [QW+1];
  side_t                sd  [QW+1];

  assign vld[0] = in_valid;
  assign dd[0]  = d_in;
  assign qq[0]  = '0;
  assign sd[0]  = side_in;

  // The dividend is the magnitude above the binary point. Since the length
  // is at least every magnitude, the quotient never exceeds one.
  for (genvar l = 0; l < 3; l++) begin : g_init
    assign rem[0][l] = {1'b0, side_in.mag[l], {FRAC_BITS{1'b0}}};
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int B = QW - 1 - s;
    logic [RW-1:0]      dsh;
    logic [2:0][RW-1:0] rem_next;
    logic [2:0][QW-1:0] q_next;

    always_comb begin
      dsh = RW'(dd[s]) << B;
      for (int l = 0; l < 3; l++) begin
        rem_next[l] = rem[s][l];
        q_next[l]   = qq[s][l];
        if (rem[s][l] >= dsh) begin
          rem_next[l]  = rem[s][l] - dsh;
          q_next[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        dd[s+1]  <= dd[s];
        rem[s+1] <= rem_next;
        qq[s+1]  <= q_next;
        sd[s+1]  <= sd[s];
      end
    end
  end

  assign out_valid = vld[QW];
  assign d_out     = dd[QW];
  assign q_out     = qq[QW];
  assign side_out  = sd[QW];

endmodule

FILE: src/vector3_alu.sv
// ----------------------------------------------------------------------------
// vector3_alu
// Pipelined three-component vector ALU in signed fixed point.
// ----------------------------------------------------------------------------
//   channel   handshake                    payload
//   item      item_valid / item_stall      item   (v3a_pkg::in_t)
//   result    result_valid / result_stall  result (v3a_pkg::out_t)
//
// One item enters per cycle while the result is not stalled; every item passes
// through 3 front stages, 32 root stages, 17 divide stages and 1 output
// stage on its way from acceptance to the output register.
// A stalled result freezes the whole pipeline, empty slots included.
// Reset clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector3_alu (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  v3a_pkg::in_t   item,
  output logic           result_valid,
  input  logic           result_stall,
  output v3a_pkg::out_t  result
);
  import v3a_pkg::*;

  logic               adv;
  logic               f_valid;
  logic [PW-1:0]      f_sumsq;
  side_t              f_side;
  logic               r_valid;
  logic [DW-1:0]      r_root;
  side_t              r_side;
  logic               d_valid;
  logic [DW-1:0]      d_len;
  logic [2:0][QW-1:0] d_q;
  side_t              d_side;

  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  v3a_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (item_valid),
    .item      (item),
    .out_valid (f_valid),
    .sumsq     (f_sumsq),
    .side      (f_side)
  );

  v3a_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (f_valid),
    .x         (f_sumsq),
    .side_in   (f_side),
    .out_valid (r_valid),
    .root_out  (r_root),
    .side_out  (r_side)
  );

  v3a_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (r_valid),
    .d_in      (r_root),
    .side_in   (r_side),
    .out_valid (d_valid),
    .d_out     (d_len),
    .q_out     (d_q),
    .side_out  (d_side)
  );

  out_t                 fin;
  logic [DW:0]          ls;
  logic [DW:0]          ns [3];
  logic signed [SW-1:0] qe [3];

  always_comb begin
    ls = sat_word({{(SW - DW){1'b0}}, d_len});
    for (int i = 0; i < 3; i++) begin
      qe[i] = {{(SW - QW){1'b0}}, d_q[i]};
      ns[i] = sat_word(d_side.neg[i] ? -qe[i] : qe[i]);
    end
    fin.res_x      = d_side.vx;
    fin.res_y      = d_side.vy;
    fin.res_z      = d_side.vz;
    fin.res_scalar = d_side.sc;
    fin.status     = d_side.status;
    case (d_side.action)
      ACT_LEN: begin
        fin.res_scalar = ls[DW-1:0];
        fin.status     = ls[DW] ? ST_SAT : ST_OK;
      end
      ACT_NORM: begin
        if (d_len == '0) begin
          fin.res_x  = '0;
          fin.res_y  = '0;
          fin.res_z  = '0;
          fin.status = ST_ZERO;
        end else begin
          fin.res_x  = ns[0][DW-1:0];
          fin.res_y  = ns[1][DW-1:0];
          fin.res_z  = ns[2][DW-1:0];
          fin.status = (ns[0][DW] || ns[1][DW] || ns[2][DW]) ? ST_SAT : ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= d_valid;
    end
    if (adv) begin
      result <= fin;
    end
  end

  // A held result must also hold back the input side.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> item_stall)
    else $error("item taken while result is stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status != 2'd3)
    else $error("undefined status code");

  a_zero_norm: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_ZERO |->
      result.res_x == '0 && result.res_y == '0 && result.res_z == '0 &&
      result.res_scalar == '0)
    else $error("zero-length normalize with nonzero result");

endmodule
